// File: hw/rtl/rtscts_pkg.sv
// Package for the RTS/CTS station controller: field widths, frame and mode codes,
// and the command/status structs shared by the controller and the datapath.
// No dependencies.
package rtscts_pkg;
	localparam int TIMER_WIDTH_DEF = 16;
	localparam int ADDRESS_WIDTH_DEF = 48;
	localparam int TYPE_W = 2;
	localparam int DUR_W = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_SEND = 2'd1;
	localparam logic [1:0] MODE_RX = 2'd2;

	localparam logic [1:0] FR_RTS = 2'd0;
	localparam logic [1:0] FR_CTS = 2'd1;
	localparam logic [1:0] FR_DATA = 2'd2;
	localparam logic [1:0] FR_ACK = 2'd3;

	localparam logic [2:0] REG_OWN = 3'd0;
	localparam logic [2:0] REG_PEER = 3'd1;
	localparam logic [2:0] REG_SIFS = 3'd2;
	localparam logic [2:0] REG_DIFS = 3'd3;
	localparam logic [2:0] REG_RESV = 3'd4;
	localparam logic [2:0] REG_MAXB = 3'd5;

	// what the datapath decoded from the latched request
	typedef struct packed {
		logic emit_rts;
		logic emit_second;
		logic [1:0] second_type;
		logic need_mod;
	} rtscts_status_t;

	// controller commands
	typedef struct packed {
		logic latch;
		logic commit;
		logic mod_start;
	} rtscts_cmd_t;
endpackage

// File: hw/rtl/rtscts_if.sv
// Valid/ready channel interface carrying one payload struct.
// Depends on nothing; the payload type is a parameter.
interface rtscts_if #(parameter type payload_t = logic) (input logic clk);
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/rtscts_mod.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
// Depends on rtscts_pkg.
module rtscts_mod import rtscts_pkg::*; #(
	parameter int W = TIMER_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [W-1:0] dividend,
	input logic [W-1:0] divisor,
	output logic busy,
	output logic [W-1:0] remainder
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0] quo_q;
	logic [W:0] rem_q;
	logic [W-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic [W:0] shifted;
	logic [W:0] diff;

	assign shifted = {rem_q[W-1:0], quo_q[W-1]};
	assign diff = shifted - {1'b0, div_q};
	assign busy = (cnt_q != '0);
	assign remainder = rem_q[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy) begin
			quo_q <= {quo_q[W-2:0], 1'b0};
			if (!diff[W]) begin
				rem_q <= diff;
			end else begin
				rem_q <= shifted;
			end
		end
	end
endmodule

// File: hw/rtl/rtscts_datapath.sv
// Datapath: configuration registers, timers, exchange state, backoff remainder
// unit and the two result slots. Depends on rtscts_pkg and rtscts_mod.
module rtscts_datapath import rtscts_pkg::*; #(
	parameter int TW = TIMER_WIDTH_DEF,
	parameter int AW = ADDRESS_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [AW-1:0] cfg_wdata,
	input logic [1:0] mode,
	input logic [1:0] rx_type,
	input logic [AW-1:0] rx_source,
	input logic [AW-1:0] rx_destination,
	input logic [DUR_W-1:0] rx_duration,
	input logic [DUR_W-1:0] backoff_draw,
	input rtscts_cmd_t cmd,
	output rtscts_status_t stat,
	output logic mod_busy,
	output logic [1:0] o_type [2],
	output logic [AW-1:0] o_src [2],
	output logic [AW-1:0] o_dst [2],
	output logic [DUR_W-1:0] o_dur [2],
	output logic o_done
);
	logic [AW-1:0] own_q, peer_q, req_addr_q;
	logic [TW-1:0] sifs_q, difs_q, maxb_q;
	logic [DUR_W-1:0] resv_q, req_dur_q;
	logic [TW-1:0] cw_t_q, bo_t_q, df_t_q, win_t_q;
	logic cw_a_q, bo_a_q, df_a_q, win_a_q;
	logic [1:0] rts_cnt_q;
	logic pend_q, fin_q;
	logic [1:0] mode_q, rtype_q;
	logic [AW-1:0] rsrc_q, rdst_q;
	logic [DUR_W-1:0] rdur_q, draw_q;
	logic [TW-1:0] mod_rem;
	logic [TW-1:0] draw_ext;

	logic w_end, c_end, b_end, d_end, for_me;

	assign draw_ext = TW'(draw_q);
	assign w_end = win_a_q && (win_t_q <= TW'(1));
	assign c_end = cw_a_q && (cw_t_q <= TW'(1));
	assign b_end = bo_a_q && (bo_t_q <= TW'(1));
	assign d_end = df_a_q && (df_t_q <= TW'(1));
	assign for_me = (rdst_q == own_q);

	rtscts_mod #(.W(TW)) u_mod (
		.clk(clk), .arst_n(arst_n), .start(cmd.mod_start),
		.dividend(draw_ext), .divisor(maxb_q),
		.busy(mod_busy), .remainder(mod_rem)
	);

	always_comb begin
		stat = '0;
		unique case (mode_q)
			MODE_TICK: begin
				stat.emit_rts = b_end || d_end;
				stat.emit_second = w_end && (rts_cnt_q == 2'd1);
				stat.second_type = FR_CTS;
				stat.need_mod = c_end && (maxb_q != '0);
			end
			MODE_SEND: stat.emit_rts = 1'b1;
			MODE_RX: begin
				if (for_me) begin
					unique case (rtype_q)
						FR_RTS: stat.emit_second = 1'b0;
						FR_CTS: begin
							stat.emit_second = 1'b1;
							stat.second_type = FR_DATA;
						end
						FR_DATA: begin
							stat.emit_second = 1'b1;
							stat.second_type = FR_ACK;
						end
						default: begin
							stat.emit_second = pend_q;
							stat.second_type = FR_DATA;
						end
					endcase
				end
			end
			default: stat = '0;
		endcase
	end

	// result slots: slot 0 RTS, slot 1 the other frame
	assign o_type[0] = FR_RTS;
	assign o_src[0] = own_q;
	assign o_dst[0] = peer_q;
	assign o_dur[0] = resv_q;
	assign o_type[1] = stat.second_type;
	assign o_src[1] = own_q;
	always_comb begin
		o_dst[1] = peer_q;
		o_dur[1] = '0;
		if (stat.second_type == FR_CTS) begin
			o_dst[1] = req_addr_q;
			o_dur[1] = req_dur_q;
		end else if (stat.second_type == FR_ACK) begin
			o_dst[1] = rsrc_q;
		end
	end
	// done as it will be after the step
	assign o_done = fin_q || (mode_q == MODE_RX && for_me && rtype_q == FR_ACK && !pend_q);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q <= mode;
			rtype_q <= rx_type;
			rsrc_q <= rx_source;
			rdst_q <= rx_destination;
			rdur_q <= rx_duration;
			draw_q <= backoff_draw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q <= '0;
			peer_q <= '0;
			sifs_q <= TW'(10);
			difs_q <= TW'(30);
			resv_q <= DUR_W'(100);
			maxb_q <= TW'(60);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_OWN: own_q <= cfg_wdata;
				REG_PEER: peer_q <= cfg_wdata;
				REG_SIFS: sifs_q <= TW'(cfg_wdata[DUR_W-1:0]);
				REG_DIFS: difs_q <= TW'(cfg_wdata[DUR_W-1:0]);
				REG_RESV: resv_q <= cfg_wdata[DUR_W-1:0];
				REG_MAXB: maxb_q <= TW'(cfg_wdata[DUR_W-1:0]);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_t_q <= '0; bo_t_q <= '0; df_t_q <= '0; win_t_q <= '0;
			cw_a_q <= 1'b0; bo_a_q <= 1'b0; df_a_q <= 1'b0; win_a_q <= 1'b0;
			rts_cnt_q <= '0;
			req_addr_q <= '0;
			req_dur_q <= '0;
			pend_q <= 1'b0;
			fin_q <= 1'b0;
		end else if (cmd.commit) begin
			unique case (mode_q)
				MODE_TICK: begin
					win_a_q <= win_a_q && !w_end;
					win_t_q <= !win_a_q ? win_t_q : (w_end ? '0 : win_t_q - 1'b1);
					cw_a_q <= cw_a_q && !c_end;
					cw_t_q <= !cw_a_q ? cw_t_q : (c_end ? '0 : cw_t_q - 1'b1);
					bo_a_q <= bo_a_q && !b_end;
					bo_t_q <= !bo_a_q ? bo_t_q : (b_end ? '0 : bo_t_q - 1'b1);
					df_a_q <= df_a_q && !d_end;
					df_t_q <= !df_a_q ? df_t_q : (d_end ? '0 : df_t_q - 1'b1);
					if (c_end) begin
						bo_a_q <= 1'b1;
						bo_t_q <= (maxb_q == '0) ? '0 : mod_rem;
					end
					if (b_end || d_end) begin
						cw_t_q <= difs_q; cw_a_q <= 1'b1;
						bo_a_q <= 1'b0; bo_t_q <= '0;
						df_a_q <= 1'b0; df_t_q <= '0;
					end
					if (w_end) rts_cnt_q <= '0;
				end
				MODE_SEND: begin
					cw_t_q <= difs_q; cw_a_q <= 1'b1;
					bo_a_q <= 1'b0; bo_t_q <= '0;
					df_a_q <= 1'b0; df_t_q <= '0;
					pend_q <= 1'b1;
				end
				MODE_RX: begin
					if (for_me) begin
						unique case (rtype_q)
							FR_RTS: begin
								if (rts_cnt_q != 2'd3) rts_cnt_q <= rts_cnt_q + 1'b1;
								if (!win_a_q) begin
									win_a_q <= 1'b1;
									win_t_q <= sifs_q;
									req_addr_q <= rsrc_q;
									req_dur_q <= rdur_q;
								end
							end
							FR_CTS: pend_q <= 1'b0;
							FR_DATA: ;
							default: begin
								if (pend_q) begin
									pend_q <= 1'b0;
								end else begin
									fin_q <= 1'b1;
									cw_a_q <= 1'b0; cw_t_q <= '0;
									bo_a_q <= 1'b0; bo_t_q <= '0;
									df_a_q <= 1'b0; df_t_q <= '0;
								end
							end
						endcase
					end else if (rtype_q == FR_CTS) begin
						cw_a_q <= 1'b0; cw_t_q <= '0;
						bo_a_q <= 1'b0; bo_t_q <= '0;
						if (!fin_q) begin
							df_t_q <= TW'(rdur_q);
							df_a_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// File: hw/rtl/rtscts_ctrl.sv
// Controller FSM: takes a request, waits for the remainder unit if needed,
// commits state and hands out up to two results. Depends on rtscts_pkg.
module rtscts_ctrl import rtscts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input rtscts_status_t stat,
	input logic mod_busy,
	output rtscts_cmd_t cmd,
	output logic out_valid,
	input logic out_ready,
	output logic out_slot,
	output logic out_last
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC = 3'd1;
	localparam logic [2:0] S_MOD = 3'd2;
	localparam logic [2:0] S_OUT0 = 3'd3;
	localparam logic [2:0] S_OUT1 = 3'd4;

	logic [2:0] st_q;
	logic has0, has1;

	assign has0 = stat.emit_rts;
	assign has1 = stat.emit_second;
	assign in_ready = (st_q == S_IDLE);
	assign out_valid = (st_q == S_OUT0) || (st_q == S_OUT1);
	assign out_slot = (st_q == S_OUT1);
	assign out_last = (st_q == S_OUT1) || !has1;

	always_comb begin
		cmd = '0;
		cmd.latch = (st_q == S_IDLE) && in_valid;
		cmd.mod_start = (st_q == S_DEC) && stat.need_mod;
		// with results, state is committed once the last result is taken, so outputs see old state
		cmd.commit = ((st_q == S_DEC) && !stat.need_mod && !has0 && !has1)
			|| ((st_q == S_MOD) && !mod_busy && !has0 && !has1)
			|| (out_valid && out_ready && out_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			unique case (st_q)
				S_IDLE: if (in_valid) st_q <= S_DEC;
				S_DEC: begin
					if (stat.need_mod) st_q <= S_MOD;
					else if (has0) st_q <= S_OUT0;
					else if (has1) st_q <= S_OUT1;
					else st_q <= S_IDLE;
				end
				S_MOD: begin
					if (!mod_busy) begin
						if (has0) st_q <= S_OUT0;
						else if (has1) st_q <= S_OUT1;
						else st_q <= S_IDLE;
					end
				end
				S_OUT0: if (out_ready) st_q <= has1 ? S_OUT1 : S_IDLE;
				S_OUT1: if (out_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: hw/rtl/rts_cts_mac_controller.sv
// RTS/CTS station controller top level.
// A request is latched in S_IDLE and decoded in S_DEC before the first result is offered; a tick
// whose CTS wait runs out also passes through S_MOD while the remainder unit runs.
// Requests: one at a time; a new request is taken only after the last result is taken.
// Reset: arst_n clears all timers and state and loads register defaults.
// Depends on rtscts_pkg, rtscts_ctrl, rtscts_datapath.
module rts_cts_mac_controller import rtscts_pkg::*; #(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF,
	parameter int ADDRESS_WIDTH = ADDRESS_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [ADDRESS_WIDTH-1:0] cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] mode,
	input logic [1:0] rx_type,
	input logic [ADDRESS_WIDTH-1:0] rx_source,
	input logic [ADDRESS_WIDTH-1:0] rx_destination,
	input logic [DUR_W-1:0] rx_duration,
	input logic [DUR_W-1:0] backoff_draw,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] tx_type,
	output logic [ADDRESS_WIDTH-1:0] tx_source,
	output logic [ADDRESS_WIDTH-1:0] tx_destination,
	output logic [DUR_W-1:0] tx_duration,
	output logic done_flag,
	output logic last_of_run
);
	rtscts_cmd_t cmd;
	rtscts_status_t stat;
	logic mod_busy, slot;
	logic [1:0] o_type [2];
	logic [ADDRESS_WIDTH-1:0] o_src [2];
	logic [ADDRESS_WIDTH-1:0] o_dst [2];
	logic [DUR_W-1:0] o_dur [2];
	logic o_done;

	rtscts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.stat(stat), .mod_busy(mod_busy), .cmd(cmd), .out_valid(out_valid),
		.out_ready(out_ready), .out_slot(slot), .out_last(last_of_run)
	);

	rtscts_datapath #(.TW(TIMER_WIDTH), .AW(ADDRESS_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .mode(mode), .rx_type(rx_type),
		.rx_source(rx_source), .rx_destination(rx_destination),
		.rx_duration(rx_duration), .backoff_draw(backoff_draw),
		.cmd(cmd), .stat(stat), .mod_busy(mod_busy),
		.o_type(o_type), .o_src(o_src), .o_dst(o_dst), .o_dur(o_dur),
		.o_done(o_done)
	);

	assign tx_type = o_type[slot];
	assign tx_source = o_src[slot];
	assign tx_destination = o_dst[slot];
	assign tx_duration = o_dur[slot];
	assign done_flag = o_done;
endmodule

// File: test/tb_rts_cts_mac_controller.sv
// Testbench for rts_cts_mac_controller: drives ticks, send requests and received frames
// with random idling, and checks every transmitted frame against a cycle-free predictor.
// Depends on rtscts_pkg, rtscts_if and the controller RTL.
`timescale 1ns / 1ps
module tb_rts_cts_mac_controller;
	import rtscts_pkg::*;

	typedef struct packed {
		logic [1:0] mode;
		logic [1:0] rx_type;
		logic [47:0] rx_source;
		logic [47:0] rx_destination;
		logic [15:0] rx_duration;
		logic [15:0] backoff_draw;
	} request_t;

	typedef struct packed {
		logic [1:0] tx_type;
		logic [47:0] tx_source;
		logic [47:0] tx_destination;
		logic [15:0] tx_duration;
		logic done_flag;
		logic last_of_run;
	} frame_t;

	typedef struct {
		request_t req;
		int n_frames;
	} directed_row_t;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [47:0] ADDR_ONES = 48'hFFFF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [47:0] cfg_wdata = '0;

	rtscts_if #(.payload_t(request_t)) req_ch (clk);
	rtscts_if #(.payload_t(frame_t)) frm_ch (clk);

	logic [1:0] o_type;
	logic [47:0] o_src, o_dst;
	logic [15:0] o_dur;
	logic o_done, o_last, o_valid;

	assign frm_ch.valid = o_valid;
	assign frm_ch.data = '{o_type, o_src, o_dst, o_dur, o_done, o_last};

	rts_cts_mac_controller u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.in_valid(req_ch.valid), .in_ready(req_ch.ready),
		.mode(req_ch.data.mode), .rx_type(req_ch.data.rx_type),
		.rx_source(req_ch.data.rx_source), .rx_destination(req_ch.data.rx_destination),
		.rx_duration(req_ch.data.rx_duration), .backoff_draw(req_ch.data.backoff_draw),
		.out_valid(o_valid), .out_ready(frm_ch.ready),
		.tx_type(o_type), .tx_source(o_src), .tx_destination(o_dst),
		.tx_duration(o_dur), .done_flag(o_done), .last_of_run(o_last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("FAILED: results differ");
		$finish;
	end

	// station model
	logic [47:0] own_addr, peer_addr, requester;
	logic [15:0] sifs, difs, resv, max_bo, req_dur;
	logic [15:0] cts_t, bo_t, df_t, win_t;
	bit cts_on, bo_on, df_on, win_on, pending, finished;
	int rts_seen;
	int last_n;
	int fails = 0;
	bit no_idle = 0;
	frame_t step_frames[$];
	frame_t expected_frames[$];

	task automatic report(string what);
		$display("ERROR at %0t: %s", $time, what);
		fails++;
	endtask

	task automatic model_reset();
		own_addr = '0; peer_addr = '0;
		sifs = 16'd10; difs = 16'd30; resv = 16'd100; max_bo = 16'd60;
		cts_t = '0; bo_t = '0; df_t = '0; win_t = '0;
		cts_on = 0; bo_on = 0; df_on = 0; win_on = 0;
		rts_seen = 0; requester = '0; req_dur = '0;
		pending = 0; finished = 0;
	endtask

	task automatic count_down(inout logic [15:0] t, inout bit on, output bit ended);
		ended = 0;
		if (on) begin
			if (t <= 16'd1) begin
				t = '0;
				on = 0;
				ended = 1;
			end else
				t = t - 16'd1;
		end
	endtask

	task automatic add_frame(logic [1:0] ty, logic [47:0] dst, logic [15:0] dur);
		frame_t f;
		f = '{ty, own_addr, dst, dur, 1'b0, 1'b0};
		step_frames = {step_frames, f};
	endtask

	task automatic launch_rts();
		add_frame(FR_RTS, peer_addr, resv);
		cts_t = difs; cts_on = 1;
		bo_on = 0; bo_t = '0;
		df_on = 0; df_t = '0;
	endtask

	task automatic predict_request(request_t r);
		bit w_end, c_end, b_end, d_end;
		step_frames.delete();
		case (r.mode)
			MODE_TICK: begin
				count_down(win_t, win_on, w_end);
				count_down(cts_t, cts_on, c_end);
				count_down(bo_t, bo_on, b_end);
				count_down(df_t, df_on, d_end);
				if (c_end) begin
					bo_t = (max_bo == 0) ? 16'd0 : r.backoff_draw % max_bo;
					bo_on = 1;
				end
				if (b_end || d_end)
					launch_rts();
				if (w_end) begin
					if (rts_seen == 1)
						add_frame(FR_CTS, requester, req_dur);
					rts_seen = 0;
				end
			end
			MODE_SEND: begin
				launch_rts();
				pending = 1;
			end
			MODE_RX: begin
				if (r.rx_destination == own_addr) begin
					case (r.rx_type)
						FR_RTS: begin
							if (rts_seen < 3)
								rts_seen++;
							if (!win_on) begin
								win_on = 1;
								win_t = sifs;
								requester = r.rx_source;
								req_dur = r.rx_duration;
							end
						end
						FR_CTS: begin
							add_frame(FR_DATA, peer_addr, 16'd0);
							pending = 0;
						end
						FR_DATA: add_frame(FR_ACK, r.rx_source, 16'd0);
						default: begin
							if (pending) begin
								add_frame(FR_DATA, peer_addr, 16'd0);
								pending = 0;
							end else begin
								finished = 1;
								cts_on = 0; cts_t = '0;
								bo_on = 0; bo_t = '0;
								df_on = 0; df_t = '0;
							end
						end
					endcase
				end else if (r.rx_type == FR_CTS) begin
					cts_on = 0; cts_t = '0;
					bo_on = 0; bo_t = '0;
					if (!finished) begin
						df_t = r.rx_duration;
						df_on = 1;
					end
				end
			end
			default: ;
		endcase
		last_n = step_frames.size();
		foreach (step_frames[k]) begin
			step_frames[k].done_flag = finished;
			step_frames[k].last_of_run = (k == step_frames.size() - 1);
			expected_frames = {expected_frames, step_frames[k]};
		end
	endtask

	always @(posedge clk)
		if (arst_n && req_ch.valid && req_ch.ready)
			predict_request(req_ch.data);

	always @(posedge clk) begin
		frame_t exp_f, got;
		if (arst_n && frm_ch.valid && frm_ch.ready) begin
			got = frm_ch.data;
			if (expected_frames.size() == 0)
				report($sformatf("unexpected frame type %0d", got.tx_type));
			else begin
				exp_f = expected_frames.pop_front();
				if (got.tx_type !== exp_f.tx_type)
					report($sformatf("tx_type %0d, want %0d", got.tx_type, exp_f.tx_type));
				if (got.tx_source !== exp_f.tx_source)
					report($sformatf("tx_source %h, want %h", got.tx_source, exp_f.tx_source));
				if (got.tx_destination !== exp_f.tx_destination)
					report($sformatf("tx_destination %h, want %h",
						got.tx_destination, exp_f.tx_destination));
				if (got.tx_duration !== exp_f.tx_duration)
					report($sformatf("tx_duration %0d, want %0d",
						got.tx_duration, exp_f.tx_duration));
				if (got.done_flag !== exp_f.done_flag)
					report($sformatf("done_flag %b, want %b", got.done_flag, exp_f.done_flag));
				if (got.last_of_run !== exp_f.last_of_run)
					report($sformatf("last_of_run %b, want %b",
						got.last_of_run, exp_f.last_of_run));
			end
		end
	end

	// frame sink with random stalls
	initial begin
		frm_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			frm_ch.ready = 1'b0;
			repeat (no_idle ? 0 : $urandom_range(0, 6)) @(negedge clk);
			frm_ch.ready = 1'b1;
			do @(posedge clk); while (!(frm_ch.valid && frm_ch.ready));
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] value);
		@(negedge clk);
		cfg_we = 1'b1; cfg_idx = idx; cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_OWN: own_addr = value;
			REG_PEER: peer_addr = value;
			REG_SIFS: sifs = value[15:0];
			REG_DIFS: difs = value[15:0];
			REG_RESV: resv = value[15:0];
			REG_MAXB: max_bo = value[15:0];
			default: ;
		endcase
	endtask

	task automatic setup(logic [47:0] own, logic [47:0] peer, logic [15:0] s, logic [15:0] d,
			logic [15:0] rv, logic [15:0] mb);
		write_reg(REG_OWN, own);
		write_reg(REG_PEER, peer);
		write_reg(REG_SIFS, {32'd0, s});
		write_reg(REG_DIFS, {32'd0, d});
		write_reg(REG_RESV, {32'd0, rv});
		write_reg(REG_MAXB, {32'd0, mb});
	endtask

	task automatic drain();
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic push_request(request_t r, int n_frames);
		@(negedge clk);
		req_ch.valid = 1'b0;
		repeat (no_idle ? 0 : $urandom_range(0, 6)) @(negedge clk);
		req_ch.data = r;
		req_ch.valid = 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		#1;
		if (n_frames >= 0 && n_frames != last_n)
			report($sformatf("request gave %0d frames, want %0d", last_n, n_frames));
	endtask

	function automatic request_t make_req(logic [1:0] m, logic [1:0] ty, logic [47:0] src,
			logic [47:0] dst, logic [15:0] dur, logic [15:0] draw);
		request_t r;
		r = '{m, ty, src, dst, dur, draw};
		return r;
	endfunction

	function automatic logic [47:0] rand_addr();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[47:0];
	endfunction

	function automatic request_t random_req();
		request_t r;
		int pick;
		pick = $urandom_range(0, 99);
		r.mode = (pick < 55) ? MODE_TICK : (pick < 63) ? MODE_SEND :
			(pick < 98) ? MODE_RX : MODE_UNUSED;
		r.rx_type = 2'($urandom_range(0, 3));
		r.rx_source = rand_addr();
		r.rx_destination = ($urandom_range(0, 9) < 7) ? own_addr : rand_addr();
		r.rx_duration = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
			16'($urandom_range(0, 20));
		r.backoff_draw = 16'($urandom);
		return r;
	endfunction

	directed_row_t plan[$];
	logic [47:0] ph_own[4], ph_peer[4];
	logic [15:0] ph_sifs[4], ph_difs[4], ph_resv[4], ph_maxb[4];

	task automatic add_row(request_t r, int n_frames);
		directed_row_t row;
		row.req = r;
		row.n_frames = n_frames;
		plan = {plan, row};
	endtask

	initial begin
		logic [47:0] sa, oa, pa;
		model_reset();
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		oa = 48'h0123_4567_89AB; pa = 48'hFEDC_BA98_7654; sa = 48'h5555_AAAA_5555;
		setup(oa, pa, 16'd2, 16'd2, 16'hFFFF, 16'd3);
		add_row(make_req(MODE_SEND, FR_RTS, '0, '0, '0, '0), 1);
		add_row(make_req(MODE_TICK, FR_RTS, '0, '0, '0, 16'hFFFF), 0);
		add_row(make_req(MODE_TICK, FR_RTS, '0, '0, '0, 16'hFFFF), 0);
		add_row(make_req(MODE_TICK, FR_RTS, '0, '0, '0, 16'h0000), 1);
		add_row(make_req(MODE_RX, FR_RTS, sa, oa, 16'hFFFF, '0), 0);
		add_row(make_req(MODE_RX, FR_RTS, ADDR_ONES, oa, 16'd7, '0), 0);
		add_row(make_req(MODE_TICK, FR_RTS, '0, '0, '0, 16'd1), -1);
		add_row(make_req(MODE_TICK, FR_RTS, '0, '0, '0, 16'd1), -1);
		add_row(make_req(MODE_RX, FR_RTS, sa, oa, 16'd0, '0), 0);
		add_row(make_req(MODE_TICK, FR_RTS, '0, '0, '0, 16'd2), -1);
		add_row(make_req(MODE_TICK, FR_RTS, '0, '0, '0, 16'd2), -1);
		add_row(make_req(MODE_RX, FR_CTS, sa, oa, '0, '0), 1);
		add_row(make_req(MODE_RX, FR_DATA, ADDR_ONES, oa, '0, '0), 1);
		add_row(make_req(MODE_RX, FR_CTS, sa, ADDR_ONES, 16'd3, '0), 0);
		add_row(make_req(MODE_TICK, FR_RTS, '0, '0, '0, '0), -1);
		add_row(make_req(MODE_TICK, FR_RTS, '0, '0, '0, '0), -1);
		add_row(make_req(MODE_TICK, FR_RTS, '0, '0, '0, '0), -1);
		add_row(make_req(MODE_RX, FR_DATA, sa, '0, '0, '0), 0);
		add_row(make_req(MODE_UNUSED, FR_ACK, ADDR_ONES, ADDR_ONES, 16'hFFFF,
			16'hFFFF), 0);
		add_row(make_req(MODE_SEND, FR_RTS, '0, '0, '0, '0), 1);
		add_row(make_req(MODE_RX, FR_ACK, sa, oa, '0, '0), 1);
		add_row(make_req(MODE_RX, FR_ACK, sa, oa, '0, '0), 0);
		add_row(make_req(MODE_RX, FR_CTS, sa, 48'd1, 16'd5, '0), 0);
		add_row(make_req(MODE_TICK, FR_RTS, '0, '0, '0, '0), 0);
		add_row(make_req(MODE_SEND, FR_RTS, '0, '0, '0, '0), 1);
		foreach (plan[i])
			push_request(plan[i].req, plan[i].n_frames);
		@(negedge clk);
		req_ch.valid = 1'b0;
		drain();

		ph_own = '{ADDR_ONES, rand_addr(), 48'd0, rand_addr()};
		ph_peer = '{48'd0, rand_addr(), ADDR_ONES, rand_addr()};
		ph_sifs = '{16'd1, 16'd3, 16'hFFFF, 16'd10};
		ph_difs = '{16'd1, 16'd5, 16'hFFFF, 16'd30};
		ph_resv = '{16'd0, 16'hFFFF, 16'd1234, 16'd100};
		ph_maxb = '{16'd1, 16'hFFFF, 16'd7, 16'd60};
		for (int p = 0; p < 4; p++) begin
			setup(ph_own[p], ph_peer[p], ph_sifs[p], ph_difs[p], ph_resv[p], ph_maxb[p]);
			no_idle = (p == 2);
			for (int i = 0; i < 120; i++)
				push_request(random_req(), -1);
			@(negedge clk);
			req_ch.valid = 1'b0;
			drain();
		end

		if (fails == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
